@@ rtl/rlr_pkg.sv @@
// ----------------------------------------------------------------------------
// rlr_pkg
// Shared types and constants for the recipient list remover.
// ----------------------------------------------------------------------------
package rlr_pkg;

  localparam int unsigned ID_W  = 64;
  localparam int unsigned VER_W = 32;
  localparam int unsigned IN_W  = 72;   // 2 + 1 + 4 + 64, padded to bytes
  localparam int unsigned OUT_W = 104;  // 64 + 1 + 1 + 1 + 32, padded to bytes

  typedef logic [ID_W-1:0]  id_t;
  typedef logic [VER_W-1:0] ver_t;

  // action codes
  localparam logic [1:0] ACT_REMOVE = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_READ   = 2'd2;

  localparam logic [3:0] SLOT_PRIMARY = 4'd0;
  localparam logic [3:0] SLOT_VIDEO   = 4'd9;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_OUT
  } rlr_state_e;

endpackage

@@ rtl/recipient_list_remover.sv @@
// ----------------------------------------------------------------------------
// recipient_list_remover
// Direct and conference recipient tables with remove, write and read.
// ----------------------------------------------------------------------------
// Requests arrive on the s_axis channel and each produces exactly one result
// on the m_axis channel. The member slots of each table sit in a row of cells
// that rotates once per request: in each scan cycle the lowest cell is
// inspected and an id (kept, cleared, shifted or written) re-enters at the
// top cell, so a full pass visits every slot in order. Video and primary
// slots are plain registers; a remove can refill a primary during the scan.
// Flow: a request is accepted in ST_IDLE, scanned in ST_SCAN, then the
// result is presented in ST_OUT. One request is in flight at a time, so the
// block takes no new request until the receiver has taken the result.
// While the receiver holds m_axis_tready low the result stays on the port
// and s_axis_tready stays low. Reset clears every table slot and the
// version counter and returns the block to idle, ready for a request.
// ----------------------------------------------------------------------------
module recipient_list_remover #(
  parameter int unsigned MEMBER_SLOTS = 8
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  // action[1:0], conference_list[2], slot[6:3], member_id[70:7], zero pad
  input  logic [rlr_pkg::IN_W-1:0]    s_axis_tdata,
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  // read_value[63:0], removed[64], promoted[65], rejected[66],
  // route_version[98:67], zero pad
  output logic [rlr_pkg::OUT_W-1:0]   m_axis_tdata
);
  import rlr_pkg::*;

  localparam int unsigned CNT_W = (MEMBER_SLOTS > 1) ? $clog2(MEMBER_SLOTS) : 1;
  localparam logic [6:0]       NSLOTS   = 7'(MEMBER_SLOTS);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MEMBER_SLOTS - 1);

  rlr_state_e state_q, state_d;

  // request
  logic       in_acc, out_acc, scan, scan_last;
  logic [1:0] in_action;
  logic       in_conf;
  logic [3:0] in_slot;
  id_t        in_id;
  logic       in_prim, in_vid, in_mem;

  logic       conf_q, conf_d;
  logic [3:0] slot_q, slot_d;
  id_t        id_q, id_d;

  // scan control
  logic             rm_dir_q, rm_dir_d;
  logic             rm_conf_q, rm_conf_d;
  logic             wr_mem_q, wr_mem_d;
  logic             rd_mem_q, rd_mem_d;
  logic             prim_hit_q, prim_hit_d;
  logic             shift_q, shift_d;
  logic             stop_q, stop_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;

  // results and tables
  logic removed_q, removed_d;
  logic promoted_q, promoted_d;
  logic rejected_q, rejected_d;
  id_t  rd_q, rd_d;
  ver_t version_q, version_d;
  id_t  video_q, video_d;
  id_t  dprim_q, dprim_d;
  id_t  cprim_q, cprim_d;

  // chains
  id_t  d_head, d_next, c_head, c_next;
  id_t  head, nxt, inject, kept;
  logic d_shift, c_shift, mem_hit;

  assign in_action = s_axis_tdata[1:0];
  assign in_conf   = s_axis_tdata[2];
  assign in_slot   = s_axis_tdata[6:3];
  assign in_id     = s_axis_tdata[70:7];

  assign in_prim = (in_slot == SLOT_PRIMARY);
  assign in_vid  = !in_conf && (in_slot == SLOT_VIDEO);
  assign in_mem  = !in_prim && !in_vid && ({3'b000, in_slot} <= NSLOTS);

  assign in_acc    = s_axis_tvalid && s_axis_tready;
  assign out_acc   = m_axis_tvalid && m_axis_tready;
  assign scan      = (state_q == ST_SCAN);
  assign scan_last = scan && (cnt_q == CNT_LAST);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: if (in_acc) state_d = ST_SCAN;
      ST_SCAN: if (scan_last) state_d = ST_OUT;
      ST_OUT:  if (out_acc) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    s_axis_tready = 1'b0;
    m_axis_tvalid = 1'b0;
    case (state_q)
      ST_IDLE: s_axis_tready = 1'b1;
      ST_OUT:  m_axis_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_axis_tdata = {5'b00000, version_q, rejected_q, promoted_q, removed_q, rd_q};

  assign d_shift = scan && !conf_q;
  assign c_shift = scan && conf_q;
  assign head    = conf_q ? c_head : d_head;
  // past the top slot the list reads as empty
  assign nxt     = (cnt_q == CNT_LAST) ? '0 : (conf_q ? c_next : d_next);
  assign mem_hit = ({3'b000, slot_q} == (7'(cnt_q) + 7'd1));

  always_comb begin
    conf_d     = conf_q;
    slot_d     = slot_q;
    id_d       = id_q;
    rm_dir_d   = rm_dir_q;
    rm_conf_d  = rm_conf_q;
    wr_mem_d   = wr_mem_q;
    rd_mem_d   = rd_mem_q;
    prim_hit_d = prim_hit_q;
    shift_d    = shift_q;
    stop_d     = stop_q;
    cnt_d      = cnt_q;
    removed_d  = removed_q;
    promoted_d = promoted_q;
    rejected_d = rejected_q;
    rd_d       = rd_q;
    version_d  = version_q;
    video_d    = video_q;
    dprim_d    = dprim_q;
    cprim_d    = cprim_q;
    inject     = head;
    kept       = head;

    if (in_acc) begin
      conf_d     = in_conf;
      slot_d     = in_slot;
      id_d       = in_id;
      rm_dir_d   = 1'b0;
      rm_conf_d  = 1'b0;
      wr_mem_d   = 1'b0;
      rd_mem_d   = 1'b0;
      prim_hit_d = 1'b0;
      shift_d    = 1'b0;
      stop_d     = 1'b0;
      cnt_d      = '0;
      removed_d  = 1'b0;
      promoted_d = 1'b0;
      rejected_d = 1'b0;
      rd_d       = '0;
      case (in_action)
        ACT_REMOVE: begin
          if (in_id == '0) begin
            rejected_d = 1'b1;
          end else begin
            version_d = version_q + 1'b1;
            if (!in_conf) begin
              if (video_q == in_id) begin
                video_d   = '0;
                removed_d = 1'b1;
              end else begin
                rm_dir_d = 1'b1;
                if (dprim_q == in_id) begin
                  dprim_d    = '0;
                  removed_d  = 1'b1;
                  prim_hit_d = 1'b1;
                end
              end
            end else begin
              rm_conf_d = 1'b1;
              // primary hit: the primary takes member 0 and the list shifts
              if (cprim_q == in_id) begin
                removed_d  = 1'b1;
                prim_hit_d = 1'b1;
                shift_d    = 1'b1;
              end
            end
          end
        end
        ACT_WRITE: begin
          if (in_prim) begin
            if (in_conf) cprim_d = in_id;
            else dprim_d = in_id;
            version_d = version_q + 1'b1;
          end else if (in_vid) begin
            video_d   = in_id;
            version_d = version_q + 1'b1;
          end else if (in_mem) begin
            wr_mem_d  = 1'b1;
            version_d = version_q + 1'b1;
          end
        end
        ACT_READ: begin
          if (in_prim) rd_d = in_conf ? cprim_q : dprim_q;
          else if (in_vid) rd_d = video_q;
          else if (in_mem) rd_mem_d = 1'b1;
        end
        default: ;
      endcase
    end else if (scan) begin
      cnt_d = cnt_q + 1'b1;
      if (rm_dir_q) begin
        if (!prim_hit_q && !removed_q && (head == id_q)) begin
          kept      = '0;
          removed_d = 1'b1;
        end
        // promote the first non-empty member into an empty primary
        if ((dprim_q == '0) && !promoted_q && (kept != '0)) begin
          dprim_d    = kept;
          kept       = '0;
          promoted_d = 1'b1;
        end
        inject = kept;
      end else if (rm_conf_q) begin
        if (shift_q) begin
          if (prim_hit_q && (cnt_q == '0)) cprim_d = head;
          inject  = nxt;
          shift_d = (nxt != '0);
        end else if (!stop_q && !removed_q && (head == id_q)) begin
          inject    = nxt;
          removed_d = 1'b1;
          shift_d   = (nxt != '0);
        end else if (head == '0) begin
          stop_d = 1'b1;
        end
      end else if (wr_mem_q) begin
        if (mem_hit) inject = id_q;
      end else if (rd_mem_q) begin
        if (mem_hit) rd_d = head;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      rm_dir_q   <= 1'b0;
      rm_conf_q  <= 1'b0;
      wr_mem_q   <= 1'b0;
      rd_mem_q   <= 1'b0;
      prim_hit_q <= 1'b0;
      shift_q    <= 1'b0;
      stop_q     <= 1'b0;
      cnt_q      <= '0;
      removed_q  <= 1'b0;
      promoted_q <= 1'b0;
      rejected_q <= 1'b0;
      version_q  <= '0;
      video_q    <= '0;
      dprim_q    <= '0;
      cprim_q    <= '0;
    end else begin
      state_q    <= state_d;
      rm_dir_q   <= rm_dir_d;
      rm_conf_q  <= rm_conf_d;
      wr_mem_q   <= wr_mem_d;
      rd_mem_q   <= rd_mem_d;
      prim_hit_q <= prim_hit_d;
      shift_q    <= shift_d;
      stop_q     <= stop_d;
      cnt_q      <= cnt_d;
      removed_q  <= removed_d;
      promoted_q <= promoted_d;
      rejected_q <= rejected_d;
      version_q  <= version_d;
      video_q    <= video_d;
      dprim_q    <= dprim_d;
      cprim_q    <= cprim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    conf_q <= conf_d;
    slot_q <= slot_d;
    id_q   <= id_d;
    rd_q   <= rd_d;
  end

  rlr_chain #(
    .MEMBER_SLOTS(MEMBER_SLOTS)
  ) u_direct (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (d_shift),
    .inject_i(inject),
    .head_o  (d_head),
    .next_o  (d_next)
  );

  rlr_chain #(
    .MEMBER_SLOTS(MEMBER_SLOTS)
  ) u_conf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .shift_i (c_shift),
    .inject_i(inject),
    .head_o  (c_head),
    .next_o  (c_next)
  );

endmodule

@@ rtl/rlr_cell.sv @@
// ----------------------------------------------------------------------------
// rlr_cell
// One member slot: holds an id and takes its neighbour's id on a shift.
// ----------------------------------------------------------------------------
module rlr_cell (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  rlr_pkg::id_t  data_i,
  output rlr_pkg::id_t  data_o
);
  import rlr_pkg::*;

  id_t value_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (shift_i) begin
      value_q <= data_i;
    end
  end

  assign data_o = value_q;

endmodule

@@ rtl/rlr_chain.sv @@
// ----------------------------------------------------------------------------
// rlr_chain
// Row of member cells forming a rotating list. On each shift every cell
// takes the id of the next one up and the top cell takes the injected id.
// ----------------------------------------------------------------------------
module rlr_chain #(
  parameter int unsigned MEMBER_SLOTS = 8
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          shift_i,
  input  rlr_pkg::id_t  inject_i,
  output rlr_pkg::id_t  head_o,
  output rlr_pkg::id_t  next_o
);
  import rlr_pkg::*;

  id_t cell_val [MEMBER_SLOTS];

  for (genvar i = 0; i < MEMBER_SLOTS; i++) begin : g_cell
    id_t cell_in;
    if (i == MEMBER_SLOTS - 1) begin : g_top
      assign cell_in = inject_i;
    end else begin : g_mid
      assign cell_in = cell_val[i+1];
    end
    rlr_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift_i),
      .data_i (cell_in),
      .data_o (cell_val[i])
    );
  end

  assign head_o = cell_val[0];

  if (MEMBER_SLOTS > 1) begin : g_next
    assign next_o = cell_val[1];
  end else begin : g_no_next
    assign next_o = '0;
  end

endmodule

@@ rtl/rlr_checker.sv @@
// ----------------------------------------------------------------------------
// rlr_checker
// Port-level checks on the recipient list remover, bound to the top level.
// ----------------------------------------------------------------------------
module rlr_checker (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      s_axis_tvalid,
  input logic                      s_axis_tready,
  input logic [rlr_pkg::IN_W-1:0]  s_axis_tdata,
  input logic                      m_axis_tvalid,
  input logic                      m_axis_tready,
  input logic [rlr_pkg::OUT_W-1:0] m_axis_tdata
);
  import rlr_pkg::*;

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // one request in flight: never ready while a result is pending
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("request taken while result pending");

  a_no_early_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !m_axis_tvalid && !s_axis_tready)
    else $error("result shown before scan");

  a_back_to_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tready |=> s_axis_tready && !m_axis_tvalid)
    else $error("no return to idle after result");

  // a rejected remove reports no removal, promotion or read value
  a_reject_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[66] |-> !m_axis_tdata[64] && !m_axis_tdata[65]
      && (m_axis_tdata[63:0] == '0))
    else $error("rejected remove with side effects");

endmodule

bind recipient_list_remover rlr_checker u_rlr_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .s_axis_tdata (s_axis_tdata),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
